// ===== src/nmdf_pkg.sv =====
// nmdf_pkg: shared constants, types and the cordic angle table for the
// nco mixer / decimating fir block
// no dependencies
package nmdf_pkg;

   // sizes of the filter and data path
   localparam int TAPS              = 127;
   localparam int SAMPLE_WIDTH      = 16;
   localparam int COEF_WIDTH        = 18;
   localparam int PHASE_WIDTH       = 32;
   localparam int TAP_ADDR_WIDTH    = $clog2(TAPS);
   localparam int TAP_COUNT_WIDTH   = $clog2(TAPS + 1);
   localparam int DL_WIDTH          = 2 * SAMPLE_WIDTH;
   localparam int COEF_INDEX_WIDTH  = 7;

   // fir accumulation
   localparam int PROD_WIDTH        = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH         = PROD_WIDTH + TAP_COUNT_WIDTH;
   localparam int ACC_SHIFT         = COEF_WIDTH - 1;
   localparam int ACC_SH_WIDTH      = ACC_WIDTH - ACC_SHIFT;

   // oscillator and mixer
   localparam int OSC_WIDTH         = 16;
   localparam int OSC_FRAC          = 15;
   localparam int OSC_PHASE_WIDTH   = 32;
   localparam int MIX_PROD_WIDTH    = SAMPLE_WIDTH + OSC_WIDTH;
   localparam int MIX_SUM_WIDTH     = MIX_PROD_WIDTH + 2;
   localparam int CORDIC_STAGES     = 30;
   localparam int CORDIC_STEP_WIDTH = $clog2(CORDIC_STAGES);
   localparam int CORDIC_WIDTH      = 33;
   localparam int CORDIC_Z_WIDTH    = 32;
   localparam int CORDIC_ANGLE_WIDTH = 30;
   localparam int CORDIC_GAIN       = 652032874;

   // decimation
   localparam int DECIM_WIDTH       = 7;
   localparam int DECIM_MAX         = 64;
   localparam int DECIM_PHASE_WIDTH = 6;

   // configuration port
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH    = 3;
   localparam logic REG_PHASE_STEP   = 1'b0;
   localparam logic REG_DECIM_FACTOR = 1'b1;

   // item modes
   localparam logic MODE_SAMPLE     = 1'b0;
   localparam logic MODE_COEF       = 1'b1;

   // oscillator result handed to the mixer
   typedef struct packed {
      logic                        done;
      logic signed [OSC_WIDTH-1:0] cos_v;
      logic signed [OSC_WIDTH-1:0] sin_v;
   } nmdf_osc_type;

   // arctangent of 2^-i in units of 2^-32 turns
   function automatic logic [CORDIC_ANGLE_WIDTH-1:0] atan_turn(
      input logic [CORDIC_STEP_WIDTH-1:0] step);
      logic [CORDIC_ANGLE_WIDTH-1:0] a;
      case (step)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         5'd24: a = 30'd41;
         5'd25: a = 30'd20;
         5'd26: a = 30'd10;
         5'd27: a = 30'd5;
         5'd28: a = 30'd3;
         5'd29: a = 30'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/nmdf_ram.sv =====
// nmdf_ram: generic simple dual-port ram, one write port, one read port,
// registered read data; no dependencies
module nmdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nmdf_cordic.sv =====
// nmdf_cordic: iterative cordic oscillator, one rotation per cycle, quadrant
// fold and rounding to q1.15; depends on nmdf_pkg
module nmdf_cordic import nmdf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [OSC_PHASE_WIDTH-1:0] phase,
   output nmdf_osc_type               osc
);

   localparam logic signed [CORDIC_WIDTH-1:0] ROUND = CORDIC_WIDTH'(1 << (OSC_FRAC - 1));
   localparam logic signed [CORDIC_WIDTH-1:0] OSC_MAX = CORDIC_WIDTH'((1 << (OSC_WIDTH - 1)) - 1);
   localparam logic signed [CORDIC_WIDTH-1:0] OSC_MIN = -OSC_MAX - CORDIC_WIDTH'(1);

   logic                                busy_ff, busy_in;
   logic                                fold_ff, fold_in;
   logic                                done_ff, done_in;
   logic [CORDIC_STEP_WIDTH-1:0]        step_ff;
   logic signed [CORDIC_WIDTH-1:0]      x_ff, y_ff;
   logic signed [CORDIC_Z_WIDTH-1:0]    z_ff;
   logic [1:0]                          quad_ff;
   logic signed [OSC_WIDTH-1:0]         cos_ff, sin_ff;

   logic signed [CORDIC_WIDTH-1:0]      dx, dy;
   logic signed [CORDIC_Z_WIDTH-1:0]    angle;
   logic signed [CORDIC_WIDTH-1:0]      rc, rs, rc_sh, rs_sh;
   logic signed [OSC_WIDTH-1:0]         cos_sat, sin_sat;

   always_comb begin
      dx    = y_ff >>> step_ff;
      dy    = x_ff >>> step_ff;
      angle = $signed(CORDIC_Z_WIDTH'(atan_turn(step_ff)));
      case (quad_ff)
         2'd1: begin
            rc = -y_ff;
            rs = x_ff;
         end
         2'd2: begin
            rc = -x_ff;
            rs = -y_ff;
         end
         2'd3: begin
            rc = y_ff;
            rs = -x_ff;
         end
         default: begin
            rc = x_ff;
            rs = y_ff;
         end
      endcase
      rc_sh = (rc + ROUND) >>> OSC_FRAC;
      rs_sh = (rs + ROUND) >>> OSC_FRAC;
      if (rc_sh > OSC_MAX) begin
         cos_sat = OSC_MAX[OSC_WIDTH-1:0];
      end else if (rc_sh < OSC_MIN) begin
         cos_sat = OSC_MIN[OSC_WIDTH-1:0];
      end else begin
         cos_sat = rc_sh[OSC_WIDTH-1:0];
      end
      if (rs_sh > OSC_MAX) begin
         sin_sat = OSC_MAX[OSC_WIDTH-1:0];
      end else if (rs_sh < OSC_MIN) begin
         sin_sat = OSC_MIN[OSC_WIDTH-1:0];
      end else begin
         sin_sat = rs_sh[OSC_WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      fold_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && step_ff == CORDIC_STEP_WIDTH'(CORDIC_STAGES - 1)) begin
         busy_in = 1'b0;
         fold_in = 1'b1;
      end
      if (fold_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fold_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fold_ff <= fold_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_WIDTH'(CORDIC_GAIN);
         y_ff    <= '0;
         z_ff    <= $signed(CORDIC_Z_WIDTH'(phase[CORDIC_ANGLE_WIDTH-1:0]));
         quad_ff <= phase[OSC_PHASE_WIDTH-1 -: 2];
         step_ff <= '0;
      end else if (busy_ff) begin
         // rotate toward the residual angle
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - angle;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + angle;
         end
         step_ff <= step_ff + 1'b1;
      end
      if (fold_ff) begin
         cos_ff <= cos_sat;
         sin_ff <= sin_sat;
      end
   end

   assign osc.done  = done_ff;
   assign osc.cos_v = cos_ff;
   assign osc.sin_v = sin_ff;

endmodule

// ===== src/nco_mixer_decimating_fir.sv =====
// nco_mixer_decimating_fir: top level, nco mixer, delay line and
// coefficient rams, shared fir mac; depends on nmdf_pkg, nmdf_ram, nmdf_cordic
//
// Digital down-converter. Each sample item is rotated to dc by a 32-bit phase
// accumulator nco (iterative cordic, one of 30 rotations per cycle), rounded
// to 16 bits and written into a 127-entry circular delay line ram. Once 127
// samples have come in, every decim_factor-th sample starts a pass of the one
// shared i/q mac over all taps, reading one coefficient and one delay line
// entry per cycle from the two rams. A coefficient load item is written as
// it is taken; a sample item waits for the cordic loop unless the phase step
// is zero. A sample that yields a result adds the mac pass over the 127 taps
// and a rounding state. Items are taken one at a time; a finished result sits
// in an output register while the next item is taken. All taps must be
// loaded before samples start.
module nco_mixer_decimating_fir import nmdf_pkg::*; (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_q,
   input  logic [COEF_INDEX_WIDTH-1:0]        req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]       req_coef_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_out_q,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]          csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]          csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]          csr_prdata,
   output logic                               csr_pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CORDIC = 3'd1;
   localparam logic [2:0] ST_MULT   = 3'd2;
   localparam logic [2:0] ST_MIX    = 3'd3;
   localparam logic [2:0] ST_MAC    = 3'd4;
   localparam logic [2:0] ST_ROUND  = 3'd5;

   localparam logic signed [MIX_SUM_WIDTH-1:0] MIX_ROUND = MIX_SUM_WIDTH'(1 << (OSC_FRAC - 1));
   localparam logic signed [ACC_WIDTH-1:0] ACC_ROUND = ACC_WIDTH'(1) << (ACC_SHIFT - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   // control state
   logic [2:0]                        state_ff, state_in;
   logic [PHASE_WIDTH-1:0]            nco_phase_ff, nco_phase_in;
   logic [TAP_COUNT_WIDTH-1:0]        fill_count_ff, fill_count_in;
   logic [DECIM_PHASE_WIDTH-1:0]      decim_phase_ff, decim_phase_in;
   logic [TAP_ADDR_WIDTH-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [TAP_ADDR_WIDTH-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [TAP_COUNT_WIDTH-1:0]        tap_ff, tap_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic                              prod_vld_ff, prod_vld_in;
   logic                              bypass_ff, bypass_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [PHASE_WIDTH-1:0]            phase_step_ff, phase_step_in;
   logic [DECIM_WIDTH-1:0]            decim_factor_ff, decim_factor_in;

   // payload
   logic signed [SAMPLE_WIDTH-1:0]    sample_i_ff, sample_q_ff;
   logic signed [MIX_PROD_WIDTH-1:0]  prod_ic_ff, prod_qs_ff, prod_is_ff, prod_qc_ff;
   logic signed [PROD_WIDTH-1:0]      mac_i_ff, mac_q_ff;
   logic signed [ACC_WIDTH-1:0]       acc_i_ff, acc_i_in, acc_q_ff, acc_q_in;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_out_i_ff, rsp_out_q_ff;

   logic                              req_accept;
   logic                              csr_write;
   logic                              rsp_load;
   logic                              mac_issue;
   logic                              mac_done;
   nmdf_osc_type                      osc;
   logic                              osc_start;
   logic [OSC_PHASE_WIDTH-1:0]        osc_phase;

   logic signed [MIX_SUM_WIDTH-1:0]   mix_i_sum, mix_q_sum, mix_i_sh, mix_q_sh;
   logic signed [SAMPLE_WIDTH-1:0]    mix_i, mix_q;
   logic signed [ACC_SH_WIDTH-1:0]    fir_i_sh, fir_q_sh;
   logic signed [SAMPLE_WIDTH-1:0]    fir_i, fir_q;

   logic [TAP_COUNT_WIDTH-1:0]        fill_next;
   logic [DECIM_WIDTH-1:0]            decim_eff;
   logic [DECIM_WIDTH-1:0]            decim_inc;
   logic [DECIM_PHASE_WIDTH-1:0]      decim_next;
   logic                              fir_due;

   logic                              coef_wr_en;
   logic [COEF_WIDTH-1:0]             coef_rd_data;
   logic                              dl_wr_en;
   logic [DL_WIDTH-1:0]               dl_wr_data;
   logic [DL_WIDTH-1:0]               dl_rd_data;
   logic signed [COEF_WIDTH-1:0]      coef_rd;
   logic signed [SAMPLE_WIDTH-1:0]    dl_i_rd, dl_q_rd;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration registers
   always_comb begin
      phase_step_in   = phase_step_ff;
      decim_factor_in = decim_factor_ff;
      if (csr_write) begin
         unique case (csr_paddr[CSR_ADDR_WIDTH-1])
            REG_PHASE_STEP:   phase_step_in   = csr_pwdata[PHASE_WIDTH-1:0];
            REG_DECIM_FACTOR: decim_factor_in = csr_pwdata[DECIM_WIDTH-1:0];
         endcase
      end
      unique case (csr_paddr[CSR_ADDR_WIDTH-1])
         REG_PHASE_STEP:   csr_prdata = CSR_DATA_WIDTH'(phase_step_ff);
         REG_DECIM_FACTOR: csr_prdata = CSR_DATA_WIDTH'(decim_factor_ff);
      endcase
   end

   // oscillator
   assign osc_start = req_accept && req_mode == MODE_SAMPLE && phase_step_ff != '0;
   assign osc_phase = OSC_PHASE_WIDTH'(nco_phase_ff) << (OSC_PHASE_WIDTH - PHASE_WIDTH);

   nmdf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (osc_start),
      .phase (osc_phase),
      .osc   (osc)
   );

   // mixer rounding and saturation
   always_comb begin
      mix_i_sum = MIX_SUM_WIDTH'(prod_ic_ff) - MIX_SUM_WIDTH'(prod_qs_ff) + MIX_ROUND;
      mix_q_sum = MIX_SUM_WIDTH'(prod_is_ff) + MIX_SUM_WIDTH'(prod_qc_ff) + MIX_ROUND;
      mix_i_sh  = mix_i_sum >>> OSC_FRAC;
      mix_q_sh  = mix_q_sum >>> OSC_FRAC;
      if (bypass_ff) begin
         mix_i = sample_i_ff;
      end else if (mix_i_sh > SAMPLE_MAX) begin
         mix_i = SAMPLE_MAX;
      end else if (mix_i_sh < SAMPLE_MIN) begin
         mix_i = SAMPLE_MIN;
      end else begin
         mix_i = mix_i_sh[SAMPLE_WIDTH-1:0];
      end
      if (bypass_ff) begin
         mix_q = sample_q_ff;
      end else if (mix_q_sh > SAMPLE_MAX) begin
         mix_q = SAMPLE_MAX;
      end else if (mix_q_sh < SAMPLE_MIN) begin
         mix_q = SAMPLE_MIN;
      end else begin
         mix_q = mix_q_sh[SAMPLE_WIDTH-1:0];
      end
      dl_wr_data = {mix_i, mix_q};
   end

   // fill and decimation bookkeeping for the sample being written
   always_comb begin
      fill_next = (fill_count_ff < TAP_COUNT_WIDTH'(TAPS)) ? fill_count_ff + 1'b1
                                                           : fill_count_ff;
      if (decim_factor_ff == '0) begin
         decim_eff = DECIM_WIDTH'(1);
      end else if (decim_factor_ff > DECIM_WIDTH'(DECIM_MAX)) begin
         decim_eff = DECIM_WIDTH'(DECIM_MAX);
      end else begin
         decim_eff = decim_factor_ff;
      end
      decim_inc  = DECIM_WIDTH'(decim_phase_ff) + 1'b1;
      decim_next = decim_phase_ff;
      fir_due    = 1'b0;
      if (fill_next < TAP_COUNT_WIDTH'(TAPS)) begin
         decim_next = decim_phase_ff;
      end else if (decim_phase_ff != '0) begin
         decim_next = (decim_inc >= decim_eff) ? '0 : decim_inc[DECIM_PHASE_WIDTH-1:0];
      end else begin
         fir_due    = 1'b1;
         decim_next = (DECIM_WIDTH'(1) >= decim_eff) ? '0 : DECIM_PHASE_WIDTH'(1);
      end
   end

   // fir rounding and saturation
   always_comb begin
      fir_i_sh = ACC_SH_WIDTH'((acc_i_ff + ACC_ROUND) >>> ACC_SHIFT);
      fir_q_sh = ACC_SH_WIDTH'((acc_q_ff + ACC_ROUND) >>> ACC_SHIFT);
      if (fir_i_sh > SAMPLE_MAX) begin
         fir_i = SAMPLE_MAX;
      end else if (fir_i_sh < SAMPLE_MIN) begin
         fir_i = SAMPLE_MIN;
      end else begin
         fir_i = fir_i_sh[SAMPLE_WIDTH-1:0];
      end
      if (fir_q_sh > SAMPLE_MAX) begin
         fir_q = SAMPLE_MAX;
      end else if (fir_q_sh < SAMPLE_MIN) begin
         fir_q = SAMPLE_MIN;
      end else begin
         fir_q = fir_q_sh[SAMPLE_WIDTH-1:0];
      end
   end

   assign mac_issue = (state_ff == ST_MAC) && (tap_ff < TAP_COUNT_WIDTH'(TAPS));
   assign mac_done  = (tap_ff == TAP_COUNT_WIDTH'(TAPS)) && !rd_vld_ff && !prod_vld_ff;
   assign rsp_load  = (state_ff == ST_ROUND) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      nco_phase_in   = nco_phase_ff;
      fill_count_in  = fill_count_ff;
      decim_phase_in = decim_phase_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      tap_in         = tap_ff;
      acc_i_in       = acc_i_ff;
      acc_q_in       = acc_q_ff;
      bypass_in      = bypass_ff;
      dl_wr_en       = 1'b0;
      rd_vld_in      = mac_issue;
      prod_vld_in    = rd_vld_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_mode == MODE_SAMPLE) begin
               nco_phase_in = nco_phase_ff + phase_step_ff;
               bypass_in    = (phase_step_ff == '0);
               state_in     = (phase_step_ff == '0) ? ST_MIX : ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (osc.done) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // newest sample goes in at the write pointer; the mac walks back from it
            dl_wr_en       = 1'b1;
            wr_ptr_in      = (wr_ptr_ff == TAP_ADDR_WIDTH'(TAPS - 1)) ? '0 : wr_ptr_ff + 1'b1;
            rd_ptr_in      = wr_ptr_ff;
            fill_count_in  = fill_next;
            decim_phase_in = decim_next;
            tap_in         = '0;
            acc_i_in       = '0;
            acc_q_in       = '0;
            state_in       = fir_due ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            if (mac_issue) begin
               tap_in    = tap_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == '0) ? TAP_ADDR_WIDTH'(TAPS - 1) : rd_ptr_ff - 1'b1;
            end
            if (prod_vld_ff) begin
               acc_i_in = acc_i_ff + ACC_WIDTH'(mac_i_ff);
               acc_q_in = acc_q_ff + ACC_WIDTH'(mac_q_ff);
            end
            if (mac_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         nco_phase_ff    <= '0;
         fill_count_ff   <= '0;
         decim_phase_ff  <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         tap_ff          <= '0;
         rd_vld_ff       <= 1'b0;
         prod_vld_ff     <= 1'b0;
         bypass_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_step_ff   <= '0;
         decim_factor_ff <= DECIM_WIDTH'(1);
      end else begin
         state_ff        <= state_in;
         nco_phase_ff    <= nco_phase_in;
         fill_count_ff   <= fill_count_in;
         decim_phase_ff  <= decim_phase_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         tap_ff          <= tap_in;
         rd_vld_ff       <= rd_vld_in;
         prod_vld_ff     <= prod_vld_in;
         bypass_ff       <= bypass_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_step_ff   <= phase_step_in;
         decim_factor_ff <= decim_factor_in;
      end
   end

   assign coef_rd = $signed(coef_rd_data);
   assign dl_i_rd = $signed(dl_rd_data[DL_WIDTH-1:SAMPLE_WIDTH]);
   assign dl_q_rd = $signed(dl_rd_data[SAMPLE_WIDTH-1:0]);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_i_ff <= req_sample_i;
         sample_q_ff <= req_sample_q;
      end
      if (state_ff == ST_MULT) begin
         prod_ic_ff <= sample_i_ff * $signed(osc.cos_v);
         prod_qs_ff <= sample_q_ff * $signed(osc.sin_v);
         prod_is_ff <= sample_i_ff * $signed(osc.sin_v);
         prod_qc_ff <= sample_q_ff * $signed(osc.cos_v);
      end
      if (rd_vld_ff) begin
         mac_i_ff <= coef_rd * dl_i_rd;
         mac_q_ff <= coef_rd * dl_q_rd;
      end
      acc_i_ff <= acc_i_in;
      acc_q_ff <= acc_q_in;
      if (rsp_load) begin
         rsp_out_i_ff <= fir_i;
         rsp_out_q_ff <= fir_q;
      end
   end

   // coefficient loads beyond the last tap are dropped
   assign coef_wr_en = req_accept && req_mode == MODE_COEF
                       && (req_coef_index < COEF_INDEX_WIDTH'(TAPS));

   nmdf_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (TAP_ADDR_WIDTH'(req_coef_index)),
      .wr_data (req_coef_value),
      .rd_en   (mac_issue),
      .rd_addr (tap_ff[TAP_ADDR_WIDTH-1:0]),
      .rd_data (coef_rd_data)
   );

   nmdf_ram #(
      .WIDTH (DL_WIDTH),
      .DEPTH (TAPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (dl_wr_data),
      .rd_en   (mac_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (dl_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_i = rsp_out_i_ff;
   assign rsp_out_q = rsp_out_q_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= TAP_COUNT_WIDTH'(TAPS))
      else $error("fill count beyond tap count");

   a_mac_needs_full_line: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> fill_count_ff == TAP_COUNT_WIDTH'(TAPS))
      else $error("mac pass started before the delay line was full");

   a_idle_mac_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rd_vld_ff && !prod_vld_ff)
      else $error("new item taken while mac pipeline still busy");

   a_osc_done_in_cordic: assert property (@(posedge clock) disable iff (reset)
      osc.done |-> state_ff == ST_CORDIC)
      else $error("oscillator finished outside the cordic wait");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the nco mixer / decimating fir block
// depends on nmdf_pkg and nco_mixer_decimating_fir; predicts every filter output
module tb_top;
   import nmdf_pkg::*;

   localparam int SETTLE_CYCLES   = 300;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int RAND_PHASES     = 9;
   localparam int PHASE_ITEMS     = 100;
   localparam longint CLIP_HI     = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint CLIP_LO     = -CLIP_HI - 1;
   localparam longint MIX_ROUND   = 64'sd1 <<< (OSC_FRAC - 1);
   localparam longint FIR_ROUND   = 64'sd1 <<< (ACC_SHIFT - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] C_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] C_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] re;
      logic signed [SAMPLE_WIDTH-1:0] im;
   } iq_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_mode;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample_i;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample_q;
   logic [COEF_INDEX_WIDTH-1:0]       req_coef_index;
   logic signed [COEF_WIDTH-1:0]      req_coef_value;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_out_i;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_out_q;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]         csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]         csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]         csr_prdata;
   logic                              csr_pready;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int n_mismatch;
   int n_samples;
   int n_loads;
   int n_outputs;

   // down-converter state as the block should hold it
   logic [PHASE_WIDTH-1:0]            step_cfg;
   logic [DECIM_WIDTH-1:0]            decim_cfg;
   logic [PHASE_WIDTH-1:0]            nco_acc;
   logic signed [SAMPLE_WIDTH-1:0]    hist_i [0:TAPS-1];
   logic signed [SAMPLE_WIDTH-1:0]    hist_q [0:TAPS-1];
   logic signed [COEF_WIDTH-1:0]      tap_coef [0:TAPS-1];
   int                                fill_cnt;
   int                                dphase;
   iq_type                            filt_pending [$];

   // rotation angles of the cordic, 2^-32 turns
   longint atan_tab [0:CORDIC_STAGES-1] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
      5, 3, 1};

   nco_mixer_decimating_fir dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_i      (rsp_out_i),
      .rsp_out_q      (rsp_out_q),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clip(input longint v);
      if (v > CLIP_HI) return CLIP_HI;
      if (v < CLIP_LO) return CLIP_LO;
      return v;
   endfunction

   // cos and sin of the oscillator phase, q1.15
   function automatic void nco_point(input logic [PHASE_WIDTH-1:0] ph,
                                     output longint c, output longint s);
      longint x, y, z, dx, dy, rc, rs;
      int k;
      x = CORDIC_GAIN;
      y = 0;
      z = {34'd0, ph[29:0]};
      for (k = 0; k < CORDIC_STAGES; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_tab[k];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_tab[k];
         end
      end
      // quadrant fold
      case (ph[31:30])
         2'd1: begin
            rc = -y;
            rs = x;
         end
         2'd2: begin
            rc = -x;
            rs = -y;
         end
         2'd3: begin
            rc = y;
            rs = -x;
         end
         default: begin
            rc = x;
            rs = y;
         end
      endcase
      c = clip((rc + MIX_ROUND) >>> OSC_FRAC);
      s = clip((rs + MIX_ROUND) >>> OSC_FRAC);
   endfunction

   // advance the down-converter by one accepted item
   function automatic void absorb_item(input logic m,
                                       input logic signed [SAMPLE_WIDTH-1:0] si, sq,
                                       input logic [COEF_INDEX_WIDTH-1:0] ci,
                                       input logic signed [COEF_WIDTH-1:0] cv);
      longint c, s, mi, mq, acc_i, acc_q;
      int dec, t;
      iq_type r;
      if (m == MODE_COEF) begin
         n_loads++;
         if (ci < TAPS) tap_coef[ci] = cv;
         return;
      end
      n_samples++;
      if (step_cfg == 0) begin
         mi = si;
         mq = sq;
      end else begin
         nco_point(nco_acc, c, s);
         mi = clip((longint'(si) * c - longint'(sq) * s + MIX_ROUND) >>> OSC_FRAC);
         mq = clip((longint'(si) * s + longint'(sq) * c + MIX_ROUND) >>> OSC_FRAC);
      end
      nco_acc = nco_acc + step_cfg;
      for (t = TAPS - 1; t > 0; t--) begin
         hist_i[t] = hist_i[t-1];
         hist_q[t] = hist_q[t-1];
      end
      hist_i[0] = mi[SAMPLE_WIDTH-1:0];
      hist_q[0] = mq[SAMPLE_WIDTH-1:0];
      if (fill_cnt < TAPS) fill_cnt++;
      if (fill_cnt < TAPS) return;
      dec = decim_cfg;
      if (dec == 0) dec = 1;
      if (dec > DECIM_MAX) dec = DECIM_MAX;
      if (dphase != 0) begin
         dphase++;
         if (dphase >= dec) dphase = 0;
         return;
      end
      dphase = 1;
      if (dphase >= dec) dphase = 0;
      acc_i = 0;
      acc_q = 0;
      for (t = 0; t < TAPS; t++) begin
         acc_i += longint'(tap_coef[t]) * longint'(hist_i[t]);
         acc_q += longint'(tap_coef[t]) * longint'(hist_q[t]);
      end
      r.re = SAMPLE_WIDTH'(clip((acc_i + FIR_ROUND) >>> ACC_SHIFT));
      r.im = SAMPLE_WIDTH'(clip((acc_q + FIR_ROUND) >>> ACC_SHIFT));
      filt_pending.push_back(r);
   endfunction

   function automatic void check_filter_output(input logic signed [SAMPLE_WIDTH-1:0] oi, oq);
      iq_type want;
      if (filt_pending.size() == 0) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("unexpected filter output i=%0d q=%0d at %0t", oi, oq, $time);
         return;
      end
      want = filt_pending.pop_front();
      n_outputs++;
      if (oi !== want.re) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("output %0d out_i: expected %0d, got %0d", n_outputs, want.re, oi);
      end
      if (oq !== want.im) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("output %0d out_q: expected %0d, got %0d", n_outputs, want.im, oq);
      end
   endfunction

   // result side: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_filter_output(rsp_out_i, rsp_out_q);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
      logic signed [SAMPLE_WIDTH-1:0] v;
      v = SAMPLE_WIDTH'($urandom);
      case ($urandom_range(7))
         0: v = S_MAX;
         1: v = S_MIN;
         2: v = v >>> 7;
         default: ;
      endcase
      return v;
   endfunction

   // random coefficient of the given magnitude in bits
   function automatic logic signed [COEF_WIDTH-1:0] rand_coef(input int bits);
      logic signed [COEF_WIDTH-1:0] v;
      v = COEF_WIDTH'($urandom);
      return v >>> (COEF_WIDTH - bits);
   endfunction

   task automatic send_item(input logic m,
                            input logic signed [SAMPLE_WIDTH-1:0] si, sq,
                            input logic [COEF_INDEX_WIDTH-1:0] ci,
                            input logic signed [COEF_WIDTH-1:0] cv);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_sample_i   <= si;
      req_sample_q   <= sq;
      req_coef_index <= ci;
      req_coef_value <= cv;
      do @(posedge clock); while (!req_ready);
      absorb_item(m, si, sq, ci, cv);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] si, sq);
      send_item(MODE_SAMPLE, si, sq, COEF_INDEX_WIDTH'($urandom), COEF_WIDTH'($urandom));
   endtask

   task automatic send_coef(input logic [COEF_INDEX_WIDTH-1:0] idx,
                            input logic signed [COEF_WIDTH-1:0] val);
      send_item(MODE_COEF, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), idx, val);
   endtask

   task automatic load_taps(input int bits);
      int t;
      for (t = 0; t < TAPS; t++) send_coef(COEF_INDEX_WIDTH'(t), rand_coef(bits));
   endtask

   // stop sending, wait for every output and for the block to go idle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (filt_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_PHASE_STEP) step_cfg = data;
      else decim_cfg = data[DECIM_WIDTH-1:0];
   endtask

   task automatic test_coef_load();
      load_taps(COEF_WIDTH);
      send_coef(0, C_MIN);
      send_coef(1, C_MAX);
      // index past the last tap is dropped
      send_coef({COEF_INDEX_WIDTH{1'b1}}, rand_coef(COEF_WIDTH));
   endtask

   // no output until the line holds a full set of samples
   task automatic test_line_fill();
      quiesce();
      csr_write(REG_PHASE_STEP, '0);
      csr_write(REG_DECIM_FACTOR, '0);
      repeat (TAPS) send_sample(rand_sample(), rand_sample());
   endtask

   task automatic test_directed_extremes();
      send_sample(S_MAX, S_MAX);
      send_sample(S_MIN, S_MIN);
      send_sample('0, '0);
      send_sample(S_MAX, S_MIN);
      send_sample(16'sh5555, -16'sh5556);
      send_coef(5, rand_coef(COEF_WIDTH));
      send_sample(-16'sd1, 16'sd1);
      send_coef({COEF_INDEX_WIDTH{1'b1}}, C_MAX);
      send_sample(S_MIN, S_MAX);
      // eighth-turn steps: full-scale inputs overflow the mixer at 45 degrees
      quiesce();
      csr_write(REG_PHASE_STEP, 32'h2000_0000);
      csr_write(REG_DECIM_FACTOR, 32'd1);
      send_sample(S_MIN, S_MIN);
      send_sample(S_MIN, S_MIN);
      send_sample(S_MAX, S_MAX);
      send_sample(S_MIN, S_MAX);
      send_sample(S_MAX, S_MIN);
      // factor above the limit acts as the limit
      quiesce();
      csr_write(REG_PHASE_STEP, '1);
      csr_write(REG_DECIM_FACTOR, 32'd127);
      repeat (3) send_sample(S_MAX, S_MIN);
      quiesce();
      csr_write(REG_PHASE_STEP, 32'h8000_0000);
      csr_write(REG_DECIM_FACTOR, DECIM_MAX);
      repeat (3) send_sample(S_MIN, S_MAX);
   endtask

   task automatic test_rx_backpressure();
      quiesce();
      csr_write(REG_PHASE_STEP, '0);
      csr_write(REG_DECIM_FACTOR, 32'd1);
      @(negedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      @(posedge clock);
      repeat (40) send_sample(rand_sample(), rand_sample());
   endtask

   task automatic test_random_traffic();
      int p, n, coef_bits;
      logic [PHASE_WIDTH-1:0] step;
      logic [DECIM_WIDTH-1:0] dec;
      coef_bits = COEF_WIDTH;
      for (p = 0; p < RAND_PHASES; p++) begin
         quiesce();
         send_idle_pct = (p < 3) ? 17 : (p < 6) ? 64 : 0;
         recv_idle_pct = (p < 3) ? 64 : (p < 6) ? 17 : 0;
         case (p)
            0: begin
               step = $urandom;
               dec = 1;
            end
            1: begin
               step = '0;
               dec = 3;
            end
            2: begin
               step = '1;
               dec = DECIM_MAX;
            end
            3: begin
               step = $urandom;
               dec = 2;
            end
            4: begin
               step = 1;
               dec = '1;
            end
            5: begin
               step = 32'h8000_0000;
               dec = '0;
            end
            6: begin
               step = $urandom;
               dec = DECIM_WIDTH'($urandom_range(16, 1));
            end
            7: begin
               step = '0;
               dec = 1;
            end
            default: begin
               step = $urandom;
               dec = 5;
            end
         endcase
         csr_write(REG_PHASE_STEP, step);
         csr_write(REG_DECIM_FACTOR, CSR_DATA_WIDTH'(dec));
         // 10-bit taps in phase 1 keep the filter out of saturation; phases 4 and 6 load wider taps
         if (p == 1 || p == 4 || p == 6) begin
            coef_bits = (p == 1) ? 10 : (p == 4) ? COEF_WIDTH : 13;
            load_taps(coef_bits);
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 8)
               send_coef(COEF_INDEX_WIDTH'($urandom_range(TAPS)), rand_coef(coef_bits));
            else
               send_sample(rand_sample(), rand_sample());
         end
      end
   endtask

   initial begin
      int t;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_SAMPLE;
      req_sample_i   = '0;
      req_sample_q   = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      step_cfg       = '0;
      decim_cfg      = 1;
      nco_acc        = '0;
      fill_cnt       = 0;
      dphase         = 0;
      for (t = 0; t < TAPS; t++) begin
         hist_i[t]   = '0;
         hist_q[t]   = '0;
         tap_coef[t] = '0;
      end
      send_idle_pct = 17;
      recv_idle_pct = 64;
      hold_cycles   = 0;
      n_mismatch    = 0;
      n_samples     = 0;
      n_loads       = 0;
      n_outputs     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_coef_load();
      test_line_fill();
      test_directed_extremes();
      test_rx_backpressure();
      test_random_traffic();
      quiesce();

      $display("covered %0d samples and %0d coefficient loads, %0d filter outputs checked",
               n_samples, n_loads, n_outputs);
      $display("phase steps 0, 1, all ones and random; decimation 0 to 127; %0d mismatches",
               n_mismatch);
      if (n_mismatch == 0 && filt_pending.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
